// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block (sfr_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/sfr_pkg.sv =====
// Types and constants of the serial frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_IDH  = 4'd1,
        PH_IDL  = 4'd2,
        PH_CMD  = 4'd3,
        PH_REQ  = 4'd4,
        PH_SIDH = 4'd5,
        PH_SIDL = 4'd6,
        PH_LEN  = 4'd7,
        PH_DATA = 4'd8,
        PH_STOP = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        ST_HEADER  = 3'd0,
        ST_KEPT    = 3'd1,
        ST_DROPPED = 3'd2,
        ST_DONE    = 3'd3,
        ST_BADSTOP = 3'd4,
        ST_REJECT  = 3'd5
    } status_t;

    typedef enum logic [7:0] {
        REG_START_BYTE  = 8'd0,
        REG_STOP_BYTE   = 8'd1,
        REG_WRITE_FLASH = 8'd2,
        REG_ERASE_FLASH = 8'd3
    } reg_index_t;

    localparam logic [7:0] ID_BYTE    = 8'h00;
    localparam logic [7:0] REQ_BYTE   = 8'h00;
    localparam logic [7:0] SID_ZERO   = 8'h00;
    localparam logic [7:0] SID_UNLK_H = 8'h55;
    localparam logic [7:0] SID_UNLK_L = 8'hAA;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] stop_byte;
        logic [7:0] write_flash_command;
        logic [7:0] erase_flash_command;
    } cfg_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_command;
        logic [7:0] frame_length;
        logic       frame_unlocked;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/serial_frame_receiver_top.sv =====
// Top level of the serial frame receiver: config registers, parser and output buffering.
//
// Takes one received byte per transaction and returns exactly one registered result per
// byte. A byte can be accepted every cycle: results go to an output register backed by a
// one-entry skid register, and in_stall is the skid occupancy, so input stalls only after
// the output side has held off for two results. Configuration writes are taken in any
// cycle (cfg_ready is always high); indexes beyond the register list are ignored.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver_top #(
    parameter int BUF_DEPTH = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      status,
    output logic [7:0]      payload_byte,
    output logic [7:0]      payload_index,
    output logic [7:0]      frame_command,
    output logic [7:0]      frame_length,
    output logic            frame_unlocked
);

    sfr_pkg::cfg_t    cfg_reg;
    sfr_pkg::result_t step_res;
    sfr_pkg::result_t out_data_reg, out_data_next;
    sfr_pkg::result_t skid_data_reg, skid_data_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             in_acc;
    logic             out_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_acc    = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sfr_pkg::REG_START_BYTE:  cfg_reg.start_byte          <= cfg_data;
                sfr_pkg::REG_STOP_BYTE:   cfg_reg.stop_byte           <= cfg_data;
                sfr_pkg::REG_WRITE_FLASH: cfg_reg.write_flash_command <= cfg_data;
                sfr_pkg::REG_ERASE_FLASH: cfg_reg.erase_flash_command <= cfg_data;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    sfr_parser #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .step    (in_acc),
        .rx_byte (rx_byte),
        .res     (step_res)
    );

    // output register with skid; skid drains first to keep order
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_acc;
                out_data_next  = step_res;
            end
        end
        else if (in_acc)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = step_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_data_reg.status;
    assign payload_byte   = out_data_reg.payload_byte;
    assign payload_index  = out_data_reg.payload_index;
    assign frame_command  = out_data_reg.frame_command;
    assign frame_length   = out_data_reg.frame_length;
    assign frame_unlocked = out_data_reg.frame_unlocked;

endmodule

`default_nettype wire

// ===== rtl/sfr_parser.sv =====
// Frame parser: phase machine, held header fields and the result of one byte.
`timescale 1ns / 1ps
`default_nettype none

module sfr_parser #(
    parameter int BUF_DEPTH = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sfr_pkg::cfg_t  cfg,
    input  wire logic           step,
    input  wire logic [7:0]     rx_byte,
    output sfr_pkg::result_t    res
);

    localparam logic [8:0] BUF_LIMIT = 9'(BUF_DEPTH);

    sfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      command_reg, command_next;
    logic [7:0]      length_reg, length_next;
    logic            unlock_reg, unlock_next;
    logic [7:0]      count_reg, count_next;

    logic            needs_unlock;
    logic [7:0]      count_inc;

    assign needs_unlock = (command_reg == cfg.write_flash_command) ||
                          (command_reg == cfg.erase_flash_command);
    assign count_inc    = count_reg + 8'd1;

    // next state and held fields
    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        unlock_next  = unlock_reg;
        count_next   = count_reg;
        case (phase_reg)
            sfr_pkg::PH_HUNT:
            begin
                if (rx_byte == cfg.start_byte)
                begin
                    phase_next  = sfr_pkg::PH_IDH;
                    length_next = 8'd0;
                    unlock_next = 1'b0;
                end
            end
            sfr_pkg::PH_IDH:
                phase_next = (rx_byte == sfr_pkg::ID_BYTE) ? sfr_pkg::PH_IDL : sfr_pkg::PH_HUNT;
            sfr_pkg::PH_IDL:
                phase_next = (rx_byte == sfr_pkg::ID_BYTE) ? sfr_pkg::PH_CMD : sfr_pkg::PH_HUNT;
            sfr_pkg::PH_CMD:
            begin
                command_next = rx_byte;
                phase_next   = sfr_pkg::PH_REQ;
            end
            sfr_pkg::PH_REQ:
                phase_next = (rx_byte == sfr_pkg::REQ_BYTE) ? sfr_pkg::PH_SIDH : sfr_pkg::PH_HUNT;
            sfr_pkg::PH_SIDH:
            begin
                if (rx_byte == (needs_unlock ? sfr_pkg::SID_UNLK_H : sfr_pkg::SID_ZERO))
                    phase_next = sfr_pkg::PH_SIDL;
                else
                    phase_next = sfr_pkg::PH_HUNT;
            end
            sfr_pkg::PH_SIDL:
            begin
                if (rx_byte == (needs_unlock ? sfr_pkg::SID_UNLK_L : sfr_pkg::SID_ZERO))
                begin
                    phase_next = sfr_pkg::PH_LEN;
                    if (needs_unlock)
                        unlock_next = 1'b1;
                end
                else
                begin
                    phase_next = sfr_pkg::PH_HUNT;
                end
            end
            sfr_pkg::PH_LEN:
            begin
                length_next = rx_byte;
                if (rx_byte != 8'd0)
                begin
                    phase_next = sfr_pkg::PH_DATA;
                    count_next = 8'd0;
                end
                else
                begin
                    phase_next = sfr_pkg::PH_STOP;
                end
            end
            sfr_pkg::PH_DATA:
            begin
                count_next = count_inc;
                if (count_inc == length_reg)
                    phase_next = sfr_pkg::PH_STOP;
            end
            sfr_pkg::PH_STOP:
                phase_next = sfr_pkg::PH_HUNT;
            default:
                phase_next = sfr_pkg::PH_HUNT;
        endcase
    end

    // result of the current byte
    always_comb
    begin
        res.status        = sfr_pkg::ST_HEADER;
        res.payload_byte  = 8'd0;
        res.payload_index = 8'd0;
        case (phase_reg)
            sfr_pkg::PH_IDH,
            sfr_pkg::PH_IDL,
            sfr_pkg::PH_REQ,
            sfr_pkg::PH_SIDH,
            sfr_pkg::PH_SIDL:
            begin
                if (phase_next == sfr_pkg::PH_HUNT)
                    res.status = sfr_pkg::ST_REJECT;
            end
            sfr_pkg::PH_DATA:
            begin
                res.payload_index = count_reg;
                if ({1'b0, count_reg} < BUF_LIMIT)
                begin
                    res.status       = sfr_pkg::ST_KEPT;
                    res.payload_byte = rx_byte;
                end
                else
                begin
                    res.status = sfr_pkg::ST_DROPPED;
                end
            end
            sfr_pkg::PH_STOP:
                res.status = (rx_byte == cfg.stop_byte) ? sfr_pkg::ST_DONE : sfr_pkg::ST_BADSTOP;
            default:
                res.status = sfr_pkg::ST_HEADER;
        endcase
        res.frame_command  = command_next;
        res.frame_length   = length_next;
        res.frame_unlocked = unlock_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sfr_pkg::PH_HUNT;
            command_reg <= 8'd0;
            length_reg  <= 8'd0;
            unlock_reg  <= 1'b0;
            count_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            unlock_reg  <= unlock_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfr_checker.sv =====
// Port-level checker of the serial frame receiver and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sfr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] status,
    input wire logic [7:0] payload_byte,
    input wire logic [7:0] payload_index,
    input wire logic [7:0] frame_length
);

    logic        kept;
    logic        no_index;
    logic        kept_ok;
    logic        stalled;
    logic [10:0] shown;

    assign kept     = out_valid && (status == sfr_pkg::ST_KEPT);
    assign no_index = (status == sfr_pkg::ST_HEADER) || (status == sfr_pkg::ST_DONE) ||
                      (status == sfr_pkg::ST_BADSTOP) || (status == sfr_pkg::ST_REJECT);
    // a kept byte has a nonzero frame length and a payload index other than 255
    assign kept_ok  = (frame_length != 8'd0) && (payload_index != 8'd255);
    assign stalled  = out_valid && out_stall;
    assign shown    = {status, payload_index};

    `ASSERT_IMPLY(a_byte_only_kept, clk, rst_n, out_valid && !kept, payload_byte == 8'd0)
    `ASSERT_IMPLY(a_index_only_payload, clk, rst_n, out_valid && no_index, payload_index == 8'd0)
    `ASSERT_IMPLY(a_kept_in_length, clk, rst_n, kept, kept_ok)
    `ASSERT_NEXT(a_stalled_holds, clk, rst_n, stalled, out_valid && $stable(shown))

endmodule

bind serial_frame_receiver_top sfr_checker u_sfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .frame_length  (frame_length)
);

`default_nettype wire

// ===== test/frame_check.sv =====
// Checker for the serial frame receiver: tracks config writes, predicts one result per byte.
`timescale 1ns / 1ps

module frame_check #(
    parameter int BUF_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] status,
    input  logic [7:0] payload_byte,
    input  logic [7:0] payload_index,
    input  logic [7:0] frame_command,
    input  logic [7:0] frame_length,
    input  logic       frame_unlocked,
    output int         mismatch_count,
    output int         results_owed
);
    import sfr_pkg::*;

    cfg_t       regs;
    phase_t     phase;
    logic [7:0] held_cmd;
    logic [7:0] held_len;
    logic [7:0] pay_count;
    logic       unlocked;
    result_t    pending_results[$];
    int         errors;

    // Header byte must match; a miss sends the parser back to the start-byte hunt.
    function automatic status_t header_step(input logic [7:0] b, input logic [7:0] want,
                                            input phase_t nxt);
        if (b != want)
        begin
            phase = PH_HUNT;
            return ST_REJECT;
        end
        phase = nxt;
        return ST_HEADER;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b);
        result_t r;
        logic    flash_cmd;
        r = '0;
        r.status = ST_HEADER;
        flash_cmd = (held_cmd == regs.write_flash_command) ||
                    (held_cmd == regs.erase_flash_command);
        case (phase)
            PH_HUNT:
                if (b == regs.start_byte)
                begin
                    phase    = PH_IDH;
                    held_len = '0;
                    unlocked = 1'b0;
                end
            PH_IDH:  r.status = header_step(b, ID_BYTE, PH_IDL);
            PH_IDL:  r.status = header_step(b, ID_BYTE, PH_CMD);
            PH_CMD:
            begin
                held_cmd = b;
                phase    = PH_REQ;
            end
            PH_REQ:  r.status = header_step(b, REQ_BYTE, PH_SIDH);
            PH_SIDH: r.status = header_step(b, flash_cmd ? SID_UNLK_H : SID_ZERO, PH_SIDL);
            PH_SIDL:
            begin
                r.status = header_step(b, flash_cmd ? SID_UNLK_L : SID_ZERO, PH_LEN);
                if (flash_cmd && r.status == ST_HEADER)
                    unlocked = 1'b1;
            end
            PH_LEN:
            begin
                held_len = b;
                if (b != 8'd0)
                begin
                    phase     = PH_DATA;
                    pay_count = '0;
                end
                else
                begin
                    phase = PH_STOP;
                end
            end
            PH_DATA:
            begin
                r.payload_index = pay_count;
                if (int'(pay_count) < BUF_DEPTH)
                begin
                    r.status       = ST_KEPT;
                    r.payload_byte = b;
                end
                else
                begin
                    r.status = ST_DROPPED;
                end
                pay_count = pay_count + 8'd1;
                if (pay_count == held_len)
                    phase = PH_STOP;
            end
            PH_STOP:
            begin
                r.status = (b == regs.stop_byte) ? ST_DONE : ST_BADSTOP;
                phase    = PH_HUNT;
            end
            default: phase = PH_HUNT;
        endcase
        r.frame_command  = held_cmd;
        r.frame_length   = held_len;
        r.frame_unlocked = unlocked;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            regs      = '0;
            phase     = PH_HUNT;
            held_cmd  = '0;
            held_len  = '0;
            pay_count = '0;
            unlocked  = 1'b0;
            errors    = 0;
            pending_results.delete();
            mismatch_count <= 0;
            results_owed   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result st=%0d byte=%02h idx=%0d", $time,
                                 status, payload_byte, payload_index);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status || payload_byte !== want.payload_byte ||
                        payload_index !== want.payload_index ||
                        frame_command !== want.frame_command ||
                        frame_length !== want.frame_length ||
                        frame_unlocked !== want.frame_unlocked)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: exp st=%0d byte=%02h idx=%0d cmd=%02h len=%0d unl=%0b",
                                     $time, want.status, want.payload_byte,
                                     want.payload_index, want.frame_command,
                                     want.frame_length, want.frame_unlocked);
                            $display("%0t: got st=%0d byte=%02h idx=%0d cmd=%02h len=%0d unl=%0b",
                                     $time, status, payload_byte, payload_index,
                                     frame_command, frame_length, frame_unlocked);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_START_BYTE:  regs.start_byte          = cfg_data;
                    REG_STOP_BYTE:   regs.stop_byte           = cfg_data;
                    REG_WRITE_FLASH: regs.write_flash_command = cfg_data;
                    REG_ERASE_FLASH: regs.erase_flash_command = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                pending_results.push_back(parse_byte(rx_byte));
            mismatch_count <= errors;
            results_owed   <= pending_results.size();
        end
    end

endmodule

// ===== test/serial_frame_receiver_top_tb.sv =====
// Testbench top for the serial frame receiver: drives frames and config, gives the verdict.
`timescale 1ns / 1ps

module serial_frame_receiver_top_tb;
    import sfr_pkg::*;

    localparam int BUF_DEPTH   = 64;
    localparam int HOLD_CYCLES = 80;

    logic       clk;
    logic       rst_n          = 1'b0;
    logic       cfg_valid      = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index      = '0;
    logic [7:0] cfg_data       = '0;
    logic       in_valid       = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte        = '0;
    logic       out_valid;
    logic       out_stall      = 1'b0;
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic       frame_unlocked;

    int         mismatch_count;
    int         results_owed;
    int         sent           = 0;
    bit         tx_quiet       = 1'b0;
    bit         rx_quiet       = 1'b0;
    bit         hold_req       = 1'b0;
    cfg_t       cur_cfg        = '0;

    // Hand-picked opening bytes for start A5 / stop 5A: noise, an ID reject,
    // a plain two-byte frame, and an unlocked zero-length frame with a bad stop.
    logic [7:0] directed_bytes [24] = '{
        8'h00, 8'hFF,
        8'hA5, 8'h01,
        8'hA5, ID_BYTE, ID_BYTE, 8'h20, REQ_BYTE, SID_ZERO, SID_ZERO, 8'h02,
        8'h00, 8'hFF, 8'h5A,
        8'hA5, ID_BYTE, ID_BYTE, 8'h11, REQ_BYTE, SID_UNLK_H, SID_UNLK_L, 8'h00, 8'h00
    };

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    serial_frame_receiver_top #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_command (frame_command),
        .frame_length  (frame_length),
        .frame_unlocked(frame_unlocked)
    );

    frame_check #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_command (frame_command),
        .frame_length  (frame_length),
        .frame_unlocked(frame_unlocked),
        .mismatch_count(mismatch_count),
        .results_owed  (results_owed)
    );

    // Result side: short random stalls, occasional long ones, and a long hold on request.
    initial
    begin : result_sink
        int stall_left;
        int roll;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                hold_req  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (rx_quiet)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    stall_left = $urandom_range(8, 30);
                else if (roll < 25)
                    stall_left = $urandom_range(1, 3);
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Returns at the edge where the byte's transaction completes, valid still high.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_config(input logic [7:0] sb, input logic [7:0] pb,
                               input logic [7:0] wf, input logic [7:0] ef);
        drain();
        write_reg(REG_START_BYTE, sb);
        write_reg(REG_STOP_BYTE, pb);
        write_reg(REG_WRITE_FLASH, wf);
        write_reg(REG_ERASE_FLASH, ef);
        cfg_valid <= 1'b0;
        cur_cfg = '{start_byte: sb, stop_byte: pb, write_flash_command: wf,
                    erase_flash_command: ef};
    endtask

    // Builds a well-formed frame; a non-negative flip_at corrupts that header byte.
    task automatic send_frame(input logic [7:0] cmd, input int len, input bit good_stop,
                              input int flip_at);
        logic [7:0] frame_bytes[$];
        bit         flash_cmd;
        flash_cmd = (cmd == cur_cfg.write_flash_command) ||
                    (cmd == cur_cfg.erase_flash_command);
        frame_bytes.push_back(cur_cfg.start_byte);
        frame_bytes.push_back(ID_BYTE);
        frame_bytes.push_back(ID_BYTE);
        frame_bytes.push_back(cmd);
        frame_bytes.push_back(REQ_BYTE);
        frame_bytes.push_back(flash_cmd ? SID_UNLK_H : SID_ZERO);
        frame_bytes.push_back(flash_cmd ? SID_UNLK_L : SID_ZERO);
        frame_bytes.push_back(8'(len));
        repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(good_stop ? cur_cfg.stop_byte
                                        : cur_cfg.stop_byte ^ 8'($urandom_range(1, 255)));
        if (flip_at >= 0)
            frame_bytes[flip_at] = frame_bytes[flip_at] ^ 8'($urandom_range(1, 255));
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
    endtask

    task automatic random_traffic(input int n_items, input bit with_max);
        int         k;
        int         kind;
        int         len;
        int         roll;
        int         flip_at;
        int         stop_at;
        logic [7:0] cmd;
        k = 0;
        stop_at = sent + n_items;
        while (sent < stop_at)
        begin
            tx_quiet = (k % 16) < 2;
            rx_quiet <= ((k % 16) >= 8) && ((k % 16) < 10);
            kind = $urandom_range(0, 99);
            if (kind < 10)
            begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: cmd = cur_cfg.write_flash_command;
                    1: cmd = cur_cfg.erase_flash_command;
                    default: cmd = 8'($urandom_range(0, 255));
                endcase
                roll = $urandom_range(0, 99);
                if (k == 2)
                    len = with_max ? 255 : $urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 36);
                else if (roll < 15)
                    len = 0;
                else if (roll < 85)
                    len = $urandom_range(1, 8);
                else if (roll < 97)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(41, 70);
                flip_at = -1;
                if (kind < 22)
                begin
                    case ($urandom_range(0, 4))
                        0: flip_at = 1;
                        1: flip_at = 2;
                        2: flip_at = 4;
                        3: flip_at = 5;
                        default: flip_at = 6;
                    endcase
                end
                send_frame(cmd, len, $urandom_range(0, 9) != 0, flip_at);
            end
            k++;
        end
        tx_quiet = 1'b0;
        rx_quiet <= 1'b0;
    endtask

    initial
    begin : stimulus
        int guard;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_config(8'hA5, 8'h5A, 8'h10, 8'h11);
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // Long hold on the result side while bytes keep coming, so the input stalls.
        drain();
        hold_req <= 1'b1;
        tx_quiet = 1'b1;
        send_frame(8'h33, 16, 1'b1, -1);
        tx_quiet = 1'b0;
        drain();

        random_traffic(180, 1'b0);
        load_config(8'h00, 8'hFF, 8'h00, 8'hFF);
        random_traffic(200, 1'b0);
        load_config(8'hFF, 8'h00, 8'hFF, 8'h00);
        random_traffic(200, 1'b1);
        load_config(8'h7E, 8'h7E, 8'h42, 8'h42);
        random_traffic(180, 1'b0);

        in_valid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (results_owed != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
